@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/u8s8dp_pkg.sv @@
`default_nettype none

package u8s8dp_pkg;

  // byte lanes carried by one beat
  localparam int BYTE_W        = 8;
  localparam int CARRIED_LANES = 16;
  localparam int HALF_LANES    = 8;

  // pair product and sum widths
  localparam int PAIR_W     = 16;
  localparam int PAIR_SUM_W = 17;
  localparam int CHUNK_W    = 19;
  localparam int SUM_W      = 32;

  localparam logic signed [PAIR_W-1:0] PAIR_MAX = 16'sh7fff;
  localparam logic signed [PAIR_W-1:0] PAIR_MIN = 16'sh8000;

  // handshake between pipeline control and the merge stage
  typedef struct packed {
    logic s2_load;
    logic s2_take;
    logic s2_last;
  } u8s8dp_ctl_t;

  // clamp a pair sum to the signed 16-bit range
  function automatic logic signed [PAIR_W-1:0] sat_pair(
    input logic signed [PAIR_SUM_W-1:0] v
  );
    logic signed [PAIR_W-1:0] res;
    if (v > PAIR_SUM_W'(PAIR_MAX)) begin
      res = PAIR_MAX;
    end else if (v < PAIR_SUM_W'(PAIR_MIN)) begin
      res = PAIR_MIN;
    end else begin
      res = v[PAIR_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/u8_s8_saturating_dot_product.sv @@
// channel   | ports                                            | direction
// ----------+--------------------------------------------------+----------
// input     | in_valid, in_stall, in_act_low/high, in_wgt_low/high, in_last_chunk | in
// result    | out_valid, out_stall, out_dot_sum                | out
//
// one beat accepted per cycle while in_stall is low; a closing beat passes both stages before out_valid rises
// three register stages: clamped pair sums, beat sum, accumulator/result register
// rst_n is synchronous; it empties the pipe and clears the accumulator
// while a result is held by out_stall, beats keep flowing until a closing beat waits
// in stage two; stage one then takes at most one more beat and in_stall rises
`default_nettype none

module u8_s8_saturating_dot_product
  import u8s8dp_pkg::*;
#(
  parameter int LANES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [63:0]        in_act_low,
  input  wire logic [63:0]        in_act_high,
  input  wire logic [63:0]        in_wgt_low,
  input  wire logic [63:0]        in_wgt_high,
  input  wire logic               in_last_chunk,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [SUM_W-1:0] out_dot_sum
);

  // lanes past the carried bytes read as zero, so only these are built
  localparam int EFF   = (LANES < CARRIED_LANES) ? LANES : CARRIED_LANES;
  localparam int PAIRS = (EFF + 1) / 2;

  logic [BYTE_W-1:0]        act_b [CARRIED_LANES];
  logic [BYTE_W-1:0]        wgt_b [CARRIED_LANES];
  logic signed [PAIR_W-1:0] pair_sum [PAIRS];

  logic s1_v_r, s1_v_nxt, s1_last_r;
  logic s2_v_r, s2_v_nxt, s2_last_r;
  logic out_v_r, out_v_nxt;
  logic out_free, s2_take, s2_open, s1_open, in_acc;
  u8s8dp_ctl_t ctl;

  // byte unpacking
  for (genvar i = 0; i < CARRIED_LANES; i++) begin : g_bytes
    if (i < HALF_LANES) begin : g_lo
      assign act_b[i] = in_act_low[BYTE_W*i +: BYTE_W];
      assign wgt_b[i] = in_wgt_low[BYTE_W*i +: BYTE_W];
    end else begin : g_hi
      assign act_b[i] = in_act_high[BYTE_W*(i-HALF_LANES) +: BYTE_W];
      assign wgt_b[i] = in_wgt_high[BYTE_W*(i-HALF_LANES) +: BYTE_W];
    end
  end

  // pipeline control
  assign out_free = !out_v_r || !out_stall;
  assign s2_take  = s2_v_r && (!s2_last_r || out_free);
  assign s2_open  = !s2_v_r || s2_take;
  assign s1_open  = !s1_v_r || s2_open;
  assign in_stall = !s1_open;
  assign in_acc   = in_valid && s1_open;

  always_comb begin
    s1_v_nxt = s1_open ? in_valid : s1_v_r;
    s2_v_nxt = s2_open ? s1_v_r : s2_v_r;
    out_v_nxt = out_v_r;
    if (s2_take && s2_last_r) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // beat markers travel with the data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r <= in_last_chunk;
    end
    if (s1_v_r && s2_open) begin
      s2_last_r <= s1_last_r;
    end
  end

  assign ctl.s2_load = s1_v_r && s2_open;
  assign ctl.s2_take = s2_take;
  assign ctl.s2_last = s2_last_r;

  // pair lanes; a lone last lane gets a zero partner
  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    logic [BYTE_W-1:0] act1;
    logic [BYTE_W-1:0] wgt1;
    if (2*p + 1 < EFF) begin : g_full
      assign act1 = act_b[2*p+1];
      assign wgt1 = wgt_b[2*p+1];
    end else begin : g_lone
      assign act1 = '0;
      assign wgt1 = '0;
    end

    u8s8dp_lane u_lane (
      .clk        (clk),
      .en         (in_acc),
      .act0       (act_b[2*p]),
      .act1       (act1),
      .wgt0       (wgt_b[2*p]),
      .wgt1       (wgt1),
      .pair_sum_r (pair_sum[p])
    );
  end

  u8s8dp_merge #(
    .PAIRS (PAIRS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .pair_sum    (pair_sum),
    .out_dot_sum (out_dot_sum)
  );

  assign out_valid = out_v_r;

endmodule

`default_nettype wire

@@ rtl/u8s8dp_lane.sv @@
`default_nettype none

module u8s8dp_lane
  import u8s8dp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [BYTE_W-1:0]        act0,
  input  wire logic [BYTE_W-1:0]        act1,
  input  wire logic [BYTE_W-1:0]        wgt0,
  input  wire logic [BYTE_W-1:0]        wgt1,
  output logic signed [PAIR_W-1:0]      pair_sum_r
);

  logic signed [PAIR_SUM_W-1:0] p0_full;
  logic signed [PAIR_SUM_W-1:0] p1_full;
  logic signed [PAIR_W-1:0]     p0;
  logic signed [PAIR_W-1:0]     p1;
  logic signed [PAIR_SUM_W-1:0] raw_sum;
  logic signed [PAIR_W-1:0]     pair_sum_nxt;

  // unsigned activation times signed weight, fits 16 bits signed
  assign p0_full = $signed({1'b0, act0}) * $signed(wgt0);
  assign p1_full = $signed({1'b0, act1}) * $signed(wgt1);
  assign p0      = p0_full[PAIR_W-1:0];
  assign p1      = p1_full[PAIR_W-1:0];

  // pair add then clamp
  assign raw_sum      = {p0[PAIR_W-1], p0} + {p1[PAIR_W-1], p1};
  assign pair_sum_nxt = sat_pair(raw_sum);

  always_ff @(posedge clk) begin
    if (en) begin
      pair_sum_r <= pair_sum_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u8s8dp_merge.sv @@
`default_nettype none

module u8s8dp_merge
  import u8s8dp_pkg::*;
#(
  parameter int PAIRS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire u8s8dp_ctl_t              ctl,
  input  wire logic signed [PAIR_W-1:0] pair_sum [PAIRS],
  output logic signed [SUM_W-1:0]       out_dot_sum
);

  logic signed [CHUNK_W-1:0] chunk_nxt;
  logic signed [CHUNK_W-1:0] chunk_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic signed [SUM_W-1:0]   acc_nxt;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [SUM_W-1:0]   out_sum_r;

  // add up the saturated pair sums of one beat
  always_comb begin
    chunk_nxt = '0;
    for (int i = 0; i < PAIRS; i++) begin
      chunk_nxt = chunk_nxt + CHUNK_W'(pair_sum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      chunk_r <= chunk_nxt;
    end
  end

  // wrapping accumulate, cleared after the closing beat
  assign acc_sum = acc_r + SUM_W'(chunk_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.s2_take) begin
      acc_nxt = ctl.s2_last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.s2_take && ctl.s2_last) begin
      out_sum_r <= acc_sum;
    end
  end

  assign out_dot_sum = out_sum_r;

endmodule

`default_nettype wire

@@ rtl/u8s8dp_chk.sv @@
`default_nettype none
`include "assert_macros.svh"

module u8s8dp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_last_chunk,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_dot_sum
);

  // a held result keeps its value
  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_dot_sum), "result changed while stalled")

  // a result only leaves through a completed beat
  `CHK_ASSERT(a_out_drop, $fell(out_valid) |-> $past(!out_stall), "result dropped without beat")

  // with no result waiting the input side is never held back
  `CHK_ASSERT_ALWAYS(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled with empty output")

  // a closing beat turns into a result if out_stall stays low while it passes stage one and stage two
  `CHK_ASSERT(a_last_latency, (in_valid && !in_stall && in_last_chunk) ##1 !out_stall ##1 !out_stall |=> out_valid, "closing beat gave no result")

endmodule

bind u8_s8_saturating_dot_product u8s8dp_chk u_chk (.*);

`default_nettype wire
